// ===== sv/rmpp_pkg.sv =====
package rmpp_pkg;

  localparam int unsigned MASK_W   = 32;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned PROD_W   = 40;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [MASK_W-1:0] RED_LAYOUT_RST   = 32'h00FF_0000;
  localparam logic [MASK_W-1:0] GREEN_LAYOUT_RST = 32'h0000_FF00;
  localparam logic [MASK_W-1:0] BLUE_LAYOUT_RST  = 32'h0000_00FF;
  localparam logic [2:0]        BPP_RST          = 3'd4;
  localparam logic              MSB_FIRST_RST    = 1'b0;

  localparam logic [2:0] BPP_MIN = 3'd2;
  localparam logic [2:0] BPP_MAX = 3'd4;

  // rounding bias of the (v*max + 127) / 255 scaling
  localparam logic [PROD_W-1:0] ROUND_BIAS = 40'd127;
  localparam logic [8:0]        DIVISOR    = 9'd255;

  typedef enum logic [2:0] {
    REG_RED_LAYOUT   = 3'd0,
    REG_GREEN_LAYOUT = 3'd1,
    REG_BLUE_LAYOUT  = 3'd2,
    REG_BPP          = 3'd3,
    REG_MSB_FIRST    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               ok;
    logic [SHIFT_W-1:0] shift;
    logic [MASK_W-1:0]  maxv;
  } chan_fmt_t;

  // trailing zero count, field maximum and contiguity of one channel mask
  function automatic chan_fmt_t mask_fmt(input logic [MASK_W-1:0] mask);
    chan_fmt_t        f;
    logic [MASK_W:0]  inc;
    f.shift = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        f.shift = SHIFT_W'(i);
      end
    end
    f.maxv = mask >> f.shift;
    inc    = {1'b0, f.maxv} + 33'd1;
    f.ok   = (mask != '0) && ((inc[MASK_W-1:0] & f.maxv) == '0);
    return f;
  endfunction

endpackage

// ===== sv/rmpp_scale.sv =====
module rmpp_scale
  import rmpp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        value,
  input  chan_fmt_t         fmt,
  output logic [MASK_W-1:0] word
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] x1;
  logic [PROD_W-1:0] x2;
  logic [PROD_W:0]   est_sum;
  logic [MASK_W-1:0] q_est;
  logic [PROD_W-1:0] mul255;
  logic [PROD_W-1:0] rem;
  logic [MASK_W-1:0] q;

  assign prod = PROD_W'(value) * PROD_W'(fmt.maxv);

  // x/255 = x/256 * (1 + 1/256 + ...); truncated series is low by at most one
  assign est_sum = {1'b0, x1} + {1'b0, x1 >> 8} + {1'b0, x1 >> 16}
                 + {1'b0, x1 >> 24} + {1'b0, x1 >> 32};

  assign mul255 = {q_est, 8'b0} - {8'b0, q_est};
  assign rem    = x2 - mul255;
  assign q      = q_est + MASK_W'(rem[8:0] >= DIVISOR);

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= prod + ROUND_BIAS;
      x2    <= x1;
      q_est <= est_sum[PROD_W-1:8];
      word  <= q << fmt.shift;
    end
  end

endmodule

// ===== sv/rgb_to_masked_pixel_packer_core.sv =====
// Packs 8-bit blue/green/red pixels into a display word laid out by three
// channel masks and streams that word out one byte per transaction.
// Slave channel: s_axis_tdata carries one pixel. Master channel:
// m_axis_tdata carries one byte, m_axis_tlast marks the pixel's final byte,
// m_axis_tuser flags a bad mask (then a single zero byte with tlast).
// Config channel: cfg_addr selects red/green/blue mask, bytes per pixel,
// byte order; cfg_ready is always high, unused indexes are dropped.
// An accepted pixel passes the input register, three scaling stages and the
// byte serialiser before its first byte is offered. Each pixel leaves as
// 2, 3 or 4 bytes (a bad format as a single byte); the single-byte output
// port paces the block. Pixels are taken back to back into the pipeline
// while the serialiser drains earlier ones, until a pixel waits in the last
// scaling stage. When the receiver stalls, the current byte holds and the
// pipeline fills, then s_axis_tready drops. Reset clears the valid flags
// and serialiser state and restores the default 32-bit 0x00RRGGBB format,
// least significant first.
module rgb_to_masked_pixel_packer_core
  import rmpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // format_error[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);

  logic [MASK_W-1:0] red_layout;
  logic [MASK_W-1:0] green_layout;
  logic [MASK_W-1:0] blue_layout;
  logic [2:0]        bytes_per_pixel;
  logic              msb_first;

  chan_fmt_t  red_fmt;
  chan_fmt_t  green_fmt;
  chan_fmt_t  blue_fmt;
  logic       fmt_err;
  logic [1:0] last_idx;
  logic [2:0] bpp_clamped;

  logic       v0, v1, v2, v3;
  logic [7:0] blue_q, green_q, red_q;
  logic       adv;
  logic       can_load;
  logic       load;

  logic [MASK_W-1:0] red_word, green_word, blue_word;

  logic              busy;
  logic [1:0]        k;
  logic [MASK_W-1:0] word;
  logic              err;
  logic              at_last;
  logic [1:0]        pos;
  logic [7:0]        byte_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_layout      <= RED_LAYOUT_RST;
      green_layout    <= GREEN_LAYOUT_RST;
      blue_layout     <= BLUE_LAYOUT_RST;
      bytes_per_pixel <= BPP_RST;
      msb_first       <= MSB_FIRST_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_RED_LAYOUT:   red_layout      <= cfg_data;
        REG_GREEN_LAYOUT: green_layout    <= cfg_data;
        REG_BLUE_LAYOUT:  blue_layout     <= cfg_data;
        REG_BPP:          bytes_per_pixel <= cfg_data[2:0];
        REG_MSB_FIRST:    msb_first       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bpp_clamped = bytes_per_pixel;
    if (bytes_per_pixel < BPP_MIN) begin
      bpp_clamped = BPP_MIN;
    end else if (bytes_per_pixel > BPP_MAX) begin
      bpp_clamped = BPP_MAX;
    end
  end

  // format decode, re-registered every cycle; settles in the cycle after a write
  always_ff @(posedge clk) begin
    red_fmt   <= mask_fmt(red_layout);
    green_fmt <= mask_fmt(green_layout);
    blue_fmt  <= mask_fmt(blue_layout);
    last_idx  <= 2'(bpp_clamped - 3'd1);
  end

  assign fmt_err = !(red_fmt.ok && green_fmt.ok && blue_fmt.ok);

  assign at_last  = err || (k == last_idx);
  assign can_load = !busy || (m_axis_tready && at_last);
  assign load     = v3 && can_load;
  assign adv      = !v3 || can_load;

  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blue_q  <= s_axis_tdata[7:0];
      green_q <= s_axis_tdata[15:8];
      red_q   <= s_axis_tdata[23:16];
    end
  end

  rmpp_scale u_red (
    .clk   (clk),
    .en    (adv),
    .value (red_q),
    .fmt   (red_fmt),
    .word  (red_word)
  );

  rmpp_scale u_green (
    .clk   (clk),
    .en    (adv),
    .value (green_q),
    .fmt   (green_fmt),
    .word  (green_word)
  );

  rmpp_scale u_blue (
    .clk   (clk),
    .en    (adv),
    .value (blue_q),
    .fmt   (blue_fmt),
    .word  (blue_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (load) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (busy && m_axis_tready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= red_word | green_word | blue_word;
      err  <= fmt_err;
    end
  end

  // three-byte words drop bits 31..24 in either order
  assign pos = msb_first ? (last_idx - k) : k;

  always_comb begin
    case (pos)
      2'd0:    byte_sel = word[7:0];
      2'd1:    byte_sel = word[15:8];
      2'd2:    byte_sel = word[23:16];
      default: byte_sel = word[31:24];
    endcase
  end

  // msb_first is sampled live; the user must change it only while the block is idle (not enforced here)
  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = err ? 8'h00 : byte_sel;
  assign m_axis_tlast  = at_last;
  assign m_axis_tuser  = err;

endmodule

// ===== sv/rmpp_checker.sv =====
module rmpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // nothing left over from before reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // a bad format gives one zero byte that closes the pixel
  a_error_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
    else $error("format error transaction is not a single zero byte");

  // bytes of one pixel follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a pixel's bytes");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

endmodule

bind rgb_to_masked_pixel_packer_core rmpp_checker u_rmpp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
